// ===== hw/rtl/rcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpp_pkg
// Shared constants, result codes and the result word type of the cartridge
// page parser.
// ----------------------------------------------------------------------------
package rcpp_pkg;

	// Number of page chunks the loader accepts and bytes stored per page.
	localparam int PAGE_COUNT = 32;
	localparam int PAGE_BYTES = 16384;
	localparam int PAGE_LIMIT = (PAGE_COUNT < 32) ? PAGE_COUNT : 32;

	// Depth of the result queue; it must hold two words beyond one in flight.
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952; // "RIFF" little-endian
	localparam logic [31:0] TAG_AMS  = 32'h2153_4D41; // "AMS!" little-endian
	localparam logic [7:0]  CHAR_C    = 8'h63;
	localparam logic [7:0]  CHAR_B    = 8'h62;
	localparam logic [7:0]  CHAR_ZERO = 8'h30;
	localparam logic [7:0]  CHAR_NINE = 8'h39;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_SIZE_LOW  = 3'd2;
	localparam logic [2:0] ST_BAD_CHUNK = 3'd3;
	localparam logic [2:0] ST_EARLY_EOF = 3'd4;
	localparam logic [2:0] ST_NO_PAGES  = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  page;
		logic [13:0] offset;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [31:0] map;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/rcpp_parser.sv =====
// ----------------------------------------------------------------------------
// rcpp_parser
// Parser state and the per-byte decode that yields up to two result words.
// ----------------------------------------------------------------------------
module rcpp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  logic             end_of_file,
	output logic [1:0]       res_cnt,
	output rcpp_pkg::result_t res0,
	output rcpp_pkg::result_t res1
);
	import rcpp_pkg::*;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_HEADER   = 3'd1;
	localparam logic [2:0] PH_CHUNK    = 3'd2;
	localparam logic [2:0] PH_DATA     = 3'd3;
	localparam logic [2:0] PH_PAD      = 3'd4;

	logic [2:0]  phase_q, phase_n, e_phase;
	logic [3:0]  fc_q, fc_n, e_fc;
	logic [31:0] sw_q, sw_n, e_sw;
	logic [31:0] riff_q, riff_n, e_riff;
	logic [31:0] size_q, size_n, e_size;
	logic [31:0] off_q, off_n, e_off;
	logic [4:0]  page_q, page_n, e_page;
	logic        flag_q, flag_n, e_flag;
	logic        any_q, any_n, e_any;
	logic [31:0] map_q, map_n, e_map;

	logic        active;
	logic        prim_v;
	result_t     prim;
	logic        fin_v;
	logic [2:0]  fin_st;
	logic        do_bnd, bnd_zero, bnd_short;
	logic [32:0] diff;
	logic [3:0]  d2, d3;
	logic [6:0]  pg;
	logic [31:0] off_inc;

	always_comb begin
		active  = first_byte || (phase_q != PH_IDLE);
		e_phase = first_byte ? PH_HEADER : phase_q;
		e_fc    = first_byte ? 4'd0 : fc_q;
		e_sw    = first_byte ? 32'd0 : sw_q;
		e_riff  = first_byte ? 32'd0 : riff_q;
		e_size  = first_byte ? 32'd0 : size_q;
		e_off   = first_byte ? 32'd0 : off_q;
		e_page  = first_byte ? 5'd0 : page_q;
		e_flag  = first_byte ? 1'b0 : flag_q;
		e_any   = first_byte ? 1'b0 : any_q;
		e_map   = first_byte ? 32'd0 : map_q;

		phase_n = e_phase;
		fc_n    = e_fc;
		sw_n    = {data_byte, e_sw[31:8]};
		riff_n  = e_riff;
		size_n  = e_size;
		off_n   = e_off;
		page_n  = e_page;
		flag_n  = e_flag;
		any_n   = e_any;
		map_n   = e_map;

		prim_v    = first_byte;
		prim      = '0;
		prim.kind = KIND_START;
		fin_v     = 1'b0;
		fin_st    = ST_OK;
		do_bnd    = 1'b0;
		bnd_zero  = 1'b0;
		bnd_short = 1'b0;

		d2      = sw_n[19:16] - CHAR_ZERO[3:0];
		d3      = sw_n[27:24] - CHAR_ZERO[3:0];
		pg      = {d2, 3'b000} + {2'b00, d2, 1'b0} + {3'b000, d3};
		// Padded size taken from the remainder in one subtract; bit 32 is the borrow.
		diff    = {1'b0, e_riff} - {1'b0, sw_n} - {32'd0, sw_n[0]};
		off_inc = e_off + 32'd1;

		case (e_phase)
			PH_HEADER: begin
				fc_n = e_fc + 4'd1;
				if (e_fc == 4'd3 && sw_n != TAG_RIFF) begin
					fin_v  = 1'b1;
					fin_st = ST_BAD_MAGIC;
				end else if (e_fc == 4'd7) begin
					riff_n = sw_n;
				end else if (e_fc == 4'd11) begin
					if (sw_n != TAG_AMS) begin
						fin_v  = 1'b1;
						fin_st = ST_BAD_MAGIC;
					end else if (e_riff < 32'd4) begin
						fin_v  = 1'b1;
						fin_st = ST_SIZE_LOW;
					end else begin
						riff_n    = e_riff - 32'd4;
						do_bnd    = 1'b1;
						bnd_zero  = (e_riff == 32'd4);
						bnd_short = (e_riff < 32'd12);
					end
				end
			end
			PH_CHUNK: begin
				fc_n = e_fc + 4'd1;
				if (e_fc == 4'd3) begin
					// The chunk header is known to fit, so the id and size come off now.
					riff_n = e_riff - 32'd8;
					flag_n = 1'b0;
					page_n = 5'd0;
					if (sw_n[7:0] == CHAR_C && sw_n[15:8] == CHAR_B &&
					    sw_n[23:16] >= CHAR_ZERO && sw_n[23:16] <= CHAR_NINE &&
					    sw_n[31:24] >= CHAR_ZERO && sw_n[31:24] <= CHAR_NINE &&
					    pg < 7'(PAGE_LIMIT)) begin
						flag_n = 1'b1;
						page_n = pg[4:0];
					end
				end else if (e_fc == 4'd7) begin
					size_n = sw_n;
					if (sw_n == 32'hFFFF_FFFF || diff[32]) begin
						fin_v  = 1'b1;
						fin_st = ST_BAD_CHUNK;
					end else begin
						riff_n = diff[31:0];
						off_n  = 32'd0;
						if (e_flag) begin
							prim_v    = 1'b1;
							prim.kind = KIND_CLEAR;
							prim.page = e_page;
						end
						if (sw_n == 32'd0) begin
							if (e_flag) begin
								map_n[e_page] = 1'b1;
								any_n         = 1'b1;
							end
							do_bnd    = 1'b1;
							bnd_zero  = (e_riff == 32'd0);
							bnd_short = (e_riff < 32'd8);
						end else begin
							phase_n = PH_DATA;
						end
					end
				end
			end
			PH_DATA: begin
				if (e_flag && e_off < 32'(PAGE_BYTES)) begin
					prim_v      = 1'b1;
					prim.kind   = KIND_WRITE;
					prim.page   = e_page;
					prim.offset = e_off[13:0];
					prim.data   = data_byte;
				end
				off_n = off_inc;
				if (off_inc == e_size) begin
					if (e_flag) begin
						map_n[e_page] = 1'b1;
						any_n         = 1'b1;
					end
					if (e_size[0]) begin
						phase_n = PH_PAD;
					end else begin
						do_bnd    = 1'b1;
						bnd_zero  = (e_riff == 32'd0);
						bnd_short = (e_riff < 32'd8);
					end
				end
			end
			PH_PAD: begin
				do_bnd    = 1'b1;
				bnd_zero  = (e_riff == 32'd0);
				bnd_short = (e_riff < 32'd8);
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		if (e_phase != PH_HEADER && e_phase != PH_CHUNK) begin
			sw_n = e_sw;
		end

		if (do_bnd) begin
			if (bnd_zero) begin
				fin_v  = 1'b1;
				fin_st = any_n ? ST_OK : ST_NO_PAGES;
			end else if (bnd_short) begin
				fin_v  = 1'b1;
				fin_st = ST_BAD_CHUNK;
			end else begin
				phase_n = PH_CHUNK;
				fc_n    = 4'd0;
			end
		end

		if (fin_v) begin
			phase_n = PH_IDLE;
		end else if (end_of_file && phase_n != PH_IDLE) begin
			fin_v   = 1'b1;
			fin_st  = ST_EARLY_EOF;
			phase_n = PH_IDLE;
		end

		prim.map  = e_map;
		prim.last = !fin_v;

		res1        = '0;
		res1.kind   = KIND_STATUS;
		res1.status = fin_st;
		res1.map    = map_n;
		res1.last   = 1'b1;

		if (!active) begin
			res_cnt = 2'd0;
			res0    = prim;
		end else if (prim_v) begin
			res_cnt = fin_v ? 2'd2 : 2'd1;
			res0    = prim;
		end else begin
			res_cnt = fin_v ? 2'd1 : 2'd0;
			res0    = res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fc_q    <= 4'd0;
			sw_q    <= 32'd0;
			riff_q  <= 32'd0;
			size_q  <= 32'd0;
			off_q   <= 32'd0;
			page_q  <= 5'd0;
			flag_q  <= 1'b0;
			any_q   <= 1'b0;
			map_q   <= 32'd0;
		end else if (fire && active) begin
			phase_q <= phase_n;
			fc_q    <= fc_n;
			sw_q    <= sw_n;
			riff_q  <= riff_n;
			size_q  <= size_n;
			off_q   <= off_n;
			page_q  <= page_n;
			flag_q  <= flag_n;
			any_q   <= any_n;
			map_q   <= map_n;
		end
	end

endmodule

// ===== hw/rtl/rcpp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rcpp_result_fifo
// Small result queue that takes up to two words a cycle and gives one.
// ----------------------------------------------------------------------------
module rcpp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  rcpp_pkg::result_t push0,
	input  rcpp_pkg::result_t push1,
	input  logic              pop,
	output rcpp_pkg::result_t head,
	output logic              not_empty,
	output logic              room
);
	import rcpp_pkg::*;

	result_t               entry_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [RESQ_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign not_empty = (count_q != '0);
	assign room      = (count_q <= RESQ_CNT_W'(RESQ_DEPTH - 2));
	assign head      = entry_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;
	assign wr_ptr_p1 = wr_ptr_q + RESQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entry_q[wr_ptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RESQ_PTR_W'(push_cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RESQ_PTR_W'(1);
			end
			count_q <= count_q + RESQ_CNT_W'(push_cnt) - RESQ_CNT_W'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/riff_cartridge_page_parser.sv =====
// ----------------------------------------------------------------------------
// riff_cartridge_page_parser
// Byte-serial loader for an AMS! RIFF cartridge image that emits page clear,
// byte write and final status words.
// ----------------------------------------------------------------------------
// Latency: a byte accepted into the input register is decoded once the result
// queue has room, and its first result word is offered right after that decode.
// Throughput: one byte per cycle while the result queue has room; a byte that
// yields two words drains them one at a time through the single read port of the result queue.
// Reset: arst_n clears the parser to waiting for a first byte and empties
// the result queue; queue contents need no reset.
// ----------------------------------------------------------------------------
module riff_cartridge_page_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [4:0]  page_number,
	output logic [13:0] byte_offset,
	output logic [7:0]  write_data,
	output logic [2:0]  status,
	output logic [31:0] present_map,
	output logic        last_result
);
	import rcpp_pkg::*;

	// Input register: one accepted byte waiting for decode.
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       first_byte_s1;
	logic       end_of_file_s1;

	logic       take;
	logic       fire;
	logic       room;
	logic [1:0] res_cnt;
	logic [1:0] push_cnt;
	result_t    res0, res1, head;

	// The decode fires only when the queue can swallow the worst case of two
	// words, so the input register drains in every cycle that the result side
	// keeps up, and a new byte is taken in the same cycle.
	assign fire       = valid_s1 && room;
	assign byte_ready = !valid_s1 || room;
	assign take       = byte_valid && byte_ready;
	assign push_cnt   = fire ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_byte_s1   <= data_byte;
			first_byte_s1  <= first_byte;
			end_of_file_s1 <= end_of_file;
		end
	end

	// Header check, chunk walk and page bookkeeping.
	rcpp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte_s1),
		.first_byte  (first_byte_s1),
		.end_of_file (end_of_file_s1),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	// Result words wait here until the consumer takes them, in order.
	rcpp_result_fifo u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (result_ready),
		.head      (head),
		.not_empty (result_valid),
		.room      (room)
	);

	assign result_kind = head.kind;
	assign page_number = head.page;
	assign byte_offset = head.offset;
	assign write_data  = head.data;
	assign status      = head.status;
	assign present_map = head.map;
	assign last_result = head.last;

endmodule

// ===== verif/rcpp_checker.sv =====
// ----------------------------------------------------------------------------
// rcpp_checker
// Watches both channels of the cartridge page parser, predicts every result
// word from the bytes it takes, and compares the words field by field.
// ----------------------------------------------------------------------------
module rcpp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        end_of_file,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [1:0]  result_kind,
	input  logic [4:0]  page_number,
	input  logic [13:0] byte_offset,
	input  logic [7:0]  write_data,
	input  logic [2:0]  status,
	input  logic [31:0] present_map,
	input  logic        last_result,
	output int          error_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import rcpp_pkg::*;

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_HEADER,
		PARSE_CHUNK_HEAD,
		PARSE_DATA,
		PARSE_PAD
	} parse_phase_e;

	parse_phase_e phase_q;
	logic [3:0]   field_cnt;
	logic [31:0]  shift_q;
	logic [31:0]  riff_left;
	logic [31:0]  chunk_len;
	logic [31:0]  chunk_pos;
	logic [4:0]   page_q;
	logic         page_flag;
	logic         seen_page;
	logic [31:0]  page_map;

	result_t expected_words[$];
	result_t byte_words[$];

	task automatic clear_state();
		phase_q   = PARSE_IDLE;
		field_cnt = '0;
		shift_q   = '0;
		riff_left = '0;
		chunk_len = '0;
		chunk_pos = '0;
		page_q    = '0;
		page_flag = 1'b0;
		seen_page = 1'b0;
		page_map  = '0;
	endtask

	task automatic emit(input logic [1:0] kind, input logic [4:0] page,
			input logic [13:0] offset, input logic [7:0] data, input logic [2:0] st);
		result_t w;
		w.kind   = kind;
		w.page   = page;
		w.offset = offset;
		w.data   = data;
		w.status = st;
		w.map    = page_map;
		w.last   = 1'b0;
		byte_words.push_back(w);
	endtask

	task automatic close_image(input logic [2:0] st);
		emit(KIND_STATUS, '0, '0, '0, st);
		phase_q = PARSE_IDLE;
	endtask

	task automatic at_boundary();
		if (riff_left == 0) begin
			close_image(seen_page ? ST_OK : ST_NO_PAGES);
		end else if (riff_left < 8) begin
			close_image(ST_BAD_CHUNK);
		end else begin
			phase_q   = PARSE_CHUNK_HEAD;
			field_cnt = '0;
		end
	endtask

	// The page counts as present once its data is in, ahead of any pad byte.
	task automatic data_done();
		if (page_flag) begin
			page_map[page_q] = 1'b1;
			seen_page = 1'b1;
		end
		if (chunk_len[0]) begin
			phase_q = PARSE_PAD;
		end else begin
			at_boundary();
		end
	endtask

	task automatic parse_byte(input logic [7:0] d, input logic f, input logic e);
		logic [3:0]  idx;
		logic [31:0] padded;
		logic [7:0]  c0, c1, c2, c3;
		int          pg;
		result_t     w;
		byte_words.delete();
		if (f) begin
			clear_state();
			emit(KIND_START, '0, '0, '0, ST_OK);
			phase_q = PARSE_HEADER;
		end else if (phase_q == PARSE_IDLE) begin
			return;
		end
		case (phase_q)
			PARSE_HEADER: begin
				idx       = field_cnt;
				shift_q   = {d, shift_q[31:8]};
				field_cnt = field_cnt + 4'd1;
				if (idx == 4'd3 && shift_q != TAG_RIFF) begin
					close_image(ST_BAD_MAGIC);
				end else if (idx == 4'd7) begin
					riff_left = shift_q;
				end else if (idx == 4'd11) begin
					if (shift_q != TAG_AMS) begin
						close_image(ST_BAD_MAGIC);
					end else if (riff_left < 4) begin
						close_image(ST_SIZE_LOW);
					end else begin
						riff_left = riff_left - 32'd4;
						at_boundary();
					end
				end
			end
			PARSE_CHUNK_HEAD: begin
				idx       = field_cnt;
				shift_q   = {d, shift_q[31:8]};
				field_cnt = field_cnt + 4'd1;
				if (idx == 4'd3) begin
					{c3, c2, c1, c0} = shift_q;
					page_flag = 1'b0;
					page_q    = '0;
					if (c0 == CHAR_C && c1 == CHAR_B && c2 >= CHAR_ZERO && c2 <= CHAR_NINE &&
							c3 >= CHAR_ZERO && c3 <= CHAR_NINE) begin
						pg = (int'(c2) - int'(CHAR_ZERO)) * 10 + (int'(c3) - int'(CHAR_ZERO));
						if (pg < PAGE_LIMIT) begin
							page_flag = 1'b1;
							page_q    = 5'(pg);
						end
					end
				end else if (idx == 4'd7) begin
					chunk_len = shift_q;
					riff_left = riff_left - 32'd8;
					if (chunk_len == 32'hFFFF_FFFF) begin
						close_image(ST_BAD_CHUNK);
					end else begin
						padded = chunk_len + {31'd0, chunk_len[0]};
						if (padded > riff_left) begin
							close_image(ST_BAD_CHUNK);
						end else begin
							riff_left = riff_left - padded;
							chunk_pos = '0;
							if (page_flag) emit(KIND_CLEAR, page_q, '0, '0, ST_OK);
							if (chunk_len == 0) begin
								data_done();
							end else begin
								phase_q = PARSE_DATA;
							end
						end
					end
				end
			end
			PARSE_DATA: begin
				if (page_flag && chunk_pos < PAGE_BYTES)
					emit(KIND_WRITE, page_q, chunk_pos[13:0], d, ST_OK);
				chunk_pos = chunk_pos + 32'd1;
				if (chunk_pos == chunk_len) data_done();
			end
			PARSE_PAD: begin
				at_boundary();
			end
			default: begin
				phase_q = PARSE_IDLE;
			end
		endcase
		if (e && phase_q != PARSE_IDLE) close_image(ST_EARLY_EOF);
		if (byte_words.size() > 0) begin
			w = byte_words[byte_words.size() - 1];
			w.last = 1'b1;
			byte_words[byte_words.size() - 1] = w;
		end
		foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	// Words leave before bytes are parsed, so a word can never match an
	// expectation made at its own edge.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_state();
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with none expected: kind %0d status %0d",
						result_kind, status);
					error_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("page_number", want.page, page_number);
					check_field("byte_offset", want.offset, byte_offset);
					check_field("write_data", want.data, write_data);
					check_field("status", want.status, status);
					check_field("present_map", want.map, present_map);
					check_field("last_result", want.last, last_result);
				end
			end
			if (byte_valid && byte_ready) parse_byte(data_byte, first_byte, end_of_file);
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the cartridge page parser: directed images for the
// header, chunk and end-of-file cases, one long page chunk under receiver
// back-pressure, then random images, mostly well formed, with bursty input
// and a stalling receiver. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcpp_pkg::*;

	// Number of random image bytes to offer after the directed part.
	localparam int RANDOM_BYTES = 230;
	// Data bytes of the long page chunk that runs under the hold-off.
	localparam int LONG_CHUNK   = 151;
	// Cycles the receiver holds off in one piece to fill the result queue.
	localparam int LONG_HOLD    = 300;
	// A byte's first word comes out of the result queue after the byte is
	// registered and decoded; this leaves room for anything stray to come out after the last expected word.
	localparam int SETTLE       = 8;
	localparam int TIMEOUT_NS   = 10_000_000;

	// One byte of an image file together with its framing flags.
	typedef struct packed {
		logic [7:0] value;
		logic       is_first;
		logic       is_eof;
	} file_byte_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte    = '0;
	logic        first_byte   = 1'b0;
	logic        end_of_file  = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [4:0]  page_number;
	logic [13:0] byte_offset;
	logic [7:0]  write_data;
	logic [2:0]  status;
	logic [31:0] present_map;
	logic        last_result;
	int          error_count;
	int          outstanding;

	// Set once by the stimulus to ask the receiver for its long hold-off.
	logic        hold_off_req = 1'b0;

	// Chunk bytes of the image being built, and the full image with flags.
	logic [7:0]  body[$];
	file_byte_t  image[$];

	int          burst_left = 0;
	bit          steady     = 1'b0;
	int          sent_count = 0;
	int          image_count;

	riff_cartridge_page_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.end_of_file  (end_of_file),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.page_number  (page_number),
		.byte_offset  (byte_offset),
		.write_data   (write_data),
		.status       (status),
		.present_map  (present_map),
		.last_result  (last_result)
	);

	rcpp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.end_of_file  (end_of_file),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.page_number  (page_number),
		.byte_offset  (byte_offset),
		.write_data   (write_data),
		.status       (status),
		.present_map  (present_map),
		.last_result  (last_result),
		.error_count  (error_count),
		.outstanding  (outstanding)
	);

	always #6 clk = ~clk;

	// A hung block must still end the run with a verdict.
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver side. It stalls on a pattern of its own that changes after a
	// random stretch: always ready, coin flip, mostly stalled, or ready in a
	// regular repeating pattern. Once asked, it holds off in one long piece
	// while the sender keeps offering bytes, so the result queue fills and
	// the block has to stall its byte input.
	initial begin
		int mode;
		int len;
		bit hold_done;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_done) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(8, 60);
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= ($urandom_range(0, 4) == 0);
					default: result_ready <= (k % 3 == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Chunk id of page pg: 'c', 'b', then two decimal digits, little-endian.
	function automatic logic [31:0] page_id(input int pg);
		return {CHAR_ZERO + 8'(pg % 10), CHAR_ZERO + 8'(pg / 10), CHAR_B, CHAR_C};
	endfunction

	task automatic push_file_byte(input logic [7:0] v, input logic f, input logic e);
		file_byte_t fb;
		fb.value    = v;
		fb.is_first = f;
		fb.is_eof   = e;
		image.push_back(fb);
	endtask

	task automatic set_eof(input int k, input logic e);
		file_byte_t fb;
		fb = image[k];
		fb.is_eof = e;
		image[k] = fb;
	endtask

	// Cuts the image short; the byte after the cut never comes.
	task automatic trim(input int n);
		while (image.size() > n) void'(image.pop_back());
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) body.push_back(w[8 * i +: 8]);
	endtask

	// Appends a chunk with random data, plus a random pad byte if odd-sized.
	// Data leans a little toward 0xFF so the top data bits see ones often.
	task automatic add_chunk(input logic [31:0] id, input int size);
		put_word(id);
		put_word(32'(size));
		for (int i = 0; i < size; i++)
			body.push_back(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom));
		if (size % 2 == 1) body.push_back(8'($urandom));
	endtask

	// Builds the whole file: tag, RIFF size, form type, then the chunks. The
	// size covers the form type and the chunks, shifted by adj to break it.
	// The first byte carries the restart flag and the last one end of file.
	task automatic compose(input logic [31:0] tag, input logic [31:0] form, input int adj);
		logic [31:0] size_word;
		image.delete();
		size_word = 32'(body.size() + 4 + adj);
		for (int i = 0; i < 4; i++) push_file_byte(tag[8 * i +: 8], i == 0, 1'b0);
		for (int i = 0; i < 4; i++) push_file_byte(size_word[8 * i +: 8], 1'b0, 1'b0);
		for (int i = 0; i < 4; i++) push_file_byte(form[8 * i +: 8], 1'b0, 1'b0);
		foreach (body[i]) push_file_byte(body[i], 1'b0, 1'b0);
		set_eof(image.size() - 1, 1'b1);
	endtask

	// Offers one byte and waits for the edge that takes it. The sender works
	// in bursts; between bursts valid drops for a random gap unless this
	// stretch is meant to run without idling.
	task automatic send_one(input file_byte_t fb);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		byte_valid  <= 1'b1;
		data_byte   <= fb.value;
		first_byte  <= fb.is_first;
		end_of_file <= fb.is_eof;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		burst_left--;
		sent_count++;
	endtask

	task automatic play();
		foreach (image[i]) send_one(image[i]);
	endtask

	// The sender pauses until every expected word has come, then waits out the
	// settle time in case the block has anything left that nobody expects.
	task automatic drain();
		byte_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		burst_left = 0;
	endtask

	// One random image. Most are well formed with a few chunks of random
	// content, so the parser gets deep into the chunk walk. The rest have a
	// bad tag or form type, a wrong RIFF size, a cut in the middle with or
	// without end of file, a stray or missing end of file, or noise bytes after the end.
	task automatic random_image();
		int          nchunks;
		int          pick;
		int          adj;
		logic [31:0] id;
		logic [31:0] tag;
		logic [31:0] form;
		body.delete();
		nchunks = $urandom_range(0, 4);
		repeat (nchunks) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				id = page_id($urandom_range(0, 31));
			end else if (pick == 6) begin
				id = page_id($urandom_range(32, 99));
			end else if (pick == 7) begin
				// Near miss of a page id: one character replaced.
				id = page_id($urandom_range(0, 31));
				id[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
			end else begin
				id = $urandom;
			end
			add_chunk(id, ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(0, 12));
		end
		tag  = TAG_RIFF;
		form = TAG_AMS;
		adj  = 0;
		if ($urandom_range(0, 24) == 0) tag = tag ^ (32'd1 << $urandom_range(0, 31));
		if ($urandom_range(0, 24) == 0) form = form ^ (32'd1 << $urandom_range(0, 31));
		if ($urandom_range(0, 9) == 0) adj = $urandom_range(0, 18) - 9;
		compose(tag, form, adj);
		if ($urandom_range(0, 3) == 0) set_eof(image.size() - 1, 1'b0);
		if ($urandom_range(0, 9) == 0) begin
			trim($urandom_range(1, image.size() - 1));
			set_eof(image.size() - 1, 1'($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 19) == 0) set_eof($urandom_range(0, image.size() - 1), 1'b1);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4))
				push_file_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
		end
		steady = ($urandom_range(0, 3) == 0);
		play();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes without a restart flag after reset are ignored, even one
		// that claims end of file.
		image.delete();
		push_file_byte(8'hFF, 1'b0, 1'b1);
		push_file_byte(8'h00, 1'b0, 1'b0);
		push_file_byte(8'h52, 1'b0, 1'b0);
		play();

		// Wrong RIFF tag is caught on its fourth byte; the rest is ignored.
		body.delete();
		compose(32'h5846_4952, TAG_AMS, 0);
		play();

		// A bad form type wins over a RIFF size below four.
		compose(TAG_RIFF, 32'h5853_4D41, -2);
		play();

		// RIFF size zero.
		compose(TAG_RIFF, TAG_AMS, -4);
		play();

		// RIFF size exactly four: the image ends right after the form type
		// with no pages, and end of file on that byte adds nothing.
		compose(TAG_RIFF, TAG_AMS, 0);
		play();

		// Five bytes left after the form type cannot hold a chunk header.
		put_word($urandom);
		body.push_back(8'h00);
		compose(TAG_RIFF, TAG_AMS, 0);
		play();

		// A good image: an odd page chunk with pad, an empty page chunk at
		// the top page, a page id just past the limit, a foreign chunk, an even
		// page chunk, and a non-digit id last, so the image completes on a pad byte.
		body.delete();
		add_chunk(page_id(0), 3);
		add_chunk(page_id(31), 0);
		add_chunk(page_id(PAGE_LIMIT), 2);
		add_chunk(32'h5453_494C, 4);
		add_chunk(page_id(5), 2);
		add_chunk({8'h3A, 8'h39, CHAR_B, CHAR_C}, 1);
		compose(TAG_RIFF, TAG_AMS, 0);
		play();

		// Chunk size of all ones.
		body.delete();
		put_word(page_id(1));
		put_word(32'hFFFF_FFFF);
		repeat (3) body.push_back(8'($urandom));
		compose(TAG_RIFF, TAG_AMS, 0);
		play();

		// Odd chunk whose pad byte would run past the RIFF size.
		body.delete();
		put_word(page_id(2));
		put_word(32'd5);
		repeat (5) body.push_back(8'($urandom));
		compose(TAG_RIFF, TAG_AMS, 0);
		play();

		// End of file in the middle of page data.
		body.delete();
		add_chunk(page_id(3), 6);
		compose(TAG_RIFF, TAG_AMS, 0);
		trim(23);
		set_eof(22, 1'b1);
		play();

		// Cut in the middle of page data; the next restart takes over.
		body.delete();
		add_chunk(page_id(4), 8);
		compose(TAG_RIFF, TAG_AMS, 0);
		trim(24);
		set_eof(23, 1'b0);
		play();

		// Restart and end of file on one byte.
		image.delete();
		push_file_byte(8'h52, 1'b1, 1'b1);
		play();
		drain();

		// One long odd-sized page chunk, so the pad is skipped after a long
		// run of writes. The receiver holds off once its current stretch ends,
		// while bytes keep coming.
		body.delete();
		add_chunk(page_id(7), LONG_CHUNK);
		add_chunk(page_id(8), 2);
		compose(TAG_RIFF, TAG_AMS, 0);
		hold_off_req <= 1'b1;
		play();
		drain();

		// Random images, with a full pause now and then.
		steady      = 1'b0;
		sent_count  = 0;
		image_count = 0;
		while (sent_count < RANDOM_BYTES) begin
			random_image();
			image_count++;
			if (image_count % 20 == 0) drain();
		end
		drain();

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
